[hw/rtl/sorted_array_min_priority_queue_macros.svh]
// ----------------------------------------------------------------------------
// sorted array min priority queue assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define SAPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sapq assertion failed");
// checked at every edge, reset included
`define SAPQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sapq assertion failed");
`else
`define SAPQ_ASSERT(label, clk, rst, prop)
`define SAPQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[hw/rtl/sapq_pkg.sv]
// ----------------------------------------------------------------------------
// sapq_pkg
// shared types, codes and constants of the sorted array min priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package sapq_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_HEAD,
    S_REM_SHIFT,
    S_FINISH
  } state_t;

  // memory read address source
  typedef enum logic [1:0] {
    RD_POS_M1,
    RD_POS_M2,
    RD_ZERO,
    RD_POS_P1
  } rd_sel_t;

  // memory write address and data source
  typedef enum logic [1:0] {
    WR_INS_VALUE,
    WR_INS_SHIFT,
    WR_REM_SHIFT
  } wr_sel_t;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    pos_zero;
    logic    pos_inc;
    logic    pos_dec;
    logic    head_load;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic pos_is_zero;
    logic pos_is_one;
    logic greater;
    logic more;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/sapq_ctrl.sv]
// ----------------------------------------------------------------------------
// sapq_ctrl
// sequencer for insert walk and remove shift over the entry memory
// ----------------------------------------------------------------------------
`default_nettype none

module sapq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sapq_pkg::dp_status_t  status,
  output sapq_pkg::dp_cmd_t     cmd
);

  import sapq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.is_remove) begin
          state_next = status.empty ? S_FINISH : S_REM_HEAD;
        end else if (status.full) begin
          state_next = S_FINISH;
        end else if (status.pos_is_zero) begin
          state_next = S_INS_PUT;
        end else begin
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (!status.greater) begin
          state_next = S_FINISH;
        end else if (status.pos_is_one) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        state_next = S_FINISH;
      end
      S_REM_HEAD: begin
        state_next = status.more ? S_REM_SHIFT : S_FINISH;
      end
      S_REM_SHIFT: begin
        if (!status.more) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_DISPATCH: begin
        if (status.is_remove) begin
          if (!status.empty) begin
            cmd.pos_zero = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_ZERO;
          end
        end else if (!status.full && !status.pos_is_zero) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_POS_M1;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (status.greater) begin
          // shift the larger entry up and look one slot lower
          cmd.wr_sel  = WR_INS_SHIFT;
          cmd.pos_dec = 1'b1;
          if (!status.pos_is_one) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_POS_M2;
          end
        end else begin
          cmd.wr_sel = WR_INS_VALUE;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_INS_VALUE;
      end
      S_REM_HEAD: begin
        cmd.head_load = 1'b1;
        if (status.more) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_POS_P1;
          cmd.pos_inc = 1'b1;
        end
      end
      S_REM_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_REM_SHIFT;
        if (status.more) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_POS_P1;
          cmd.pos_inc = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.out_load = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/sapq_dp.sv]
// ----------------------------------------------------------------------------
// sapq_dp
// entry memory, walk pointer, fill count and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_array_min_priority_queue_macros.svh"

module sapq_dp #(
  parameter int CAPACITY = sapq_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sapq_pkg::dp_cmd_t                      cmd,
  output sapq_pkg::dp_status_t                   status,
  input  logic                                   req_type,
  input  logic signed [sapq_pkg::VALUE_W-1:0]    insert_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sapq_pkg::STATUS_W-1:0]          out_status,
  output logic signed [sapq_pkg::VALUE_W-1:0]    out_removed,
  output logic [sapq_pkg::COUNT_OUT_W-1:0]       out_count
);

  import sapq_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  logic signed [VALUE_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [CNT_W-1:0]          pos;
  logic [CNT_W-1:0]          pos_m1;
  logic [CNT_W-1:0]          pos_m2;
  logic [CNT_W-1:0]          pos_p1;
  logic                      req;
  logic signed [VALUE_W-1:0] value;
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] head;
  logic [CNT_W-1:0]          rd_idx;
  logic [CNT_W-1:0]          wr_idx;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      full;
  logic                      empty;
  logic [STATUS_W-1:0]       res_status;
  logic signed [VALUE_W-1:0] res_removed;

  assign pos_m1 = pos - CNT_W'(1);
  assign pos_m2 = pos - CNT_W'(2);
  assign pos_p1 = pos + CNT_W'(1);
  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);

  always_comb begin
    case (cmd.rd_sel)
      RD_POS_M1: rd_idx = pos_m1;
      RD_POS_M2: rd_idx = pos_m2;
      RD_ZERO:   rd_idx = '0;
      RD_POS_P1: rd_idx = pos_p1;
      default:   rd_idx = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_INS_VALUE: begin
        wr_idx  = pos;
        wr_data = value;
      end
      WR_INS_SHIFT: begin
        wr_idx  = pos;
        wr_data = rd_data;
      end
      WR_REM_SHIFT: begin
        wr_idx  = pos_m1;
        wr_data = rd_data;
      end
      default: begin
        wr_idx  = pos;
        wr_data = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_idx[ADDR_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  // request latch and walk pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req   <= req_type;
      value <= insert_value;
    end
    if (cmd.head_load) begin
      head <= rd_data;
    end
    if (rst) begin
      pos <= '0;
    end else if (cmd.accept) begin
      pos <= count;
    end else if (cmd.pos_zero) begin
      pos <= '0;
    end else if (cmd.pos_inc) begin
      pos <= pos_p1;
    end else if (cmd.pos_dec) begin
      pos <= pos_m1;
    end
  end

  always_comb begin
    count_next  = count;
    res_status  = ST_DONE;
    res_removed = '0;
    if (req == REQ_INSERT) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        res_status = ST_EMPTY;
      end else begin
        count_next  = count - CNT_W'(1);
        res_removed = head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status  <= res_status;
      out_removed <= res_removed;
      // entry count saturates at the field maximum
      if (32'(count_next) > 32'(2**COUNT_OUT_W - 1)) begin
        out_count <= '1;
      end else begin
        out_count <= COUNT_OUT_W'(count_next);
      end
    end
  end

  always_comb begin
    status.is_remove   = (req == REQ_REMOVE);
    status.full        = full;
    status.empty       = empty;
    status.pos_is_zero = (pos == '0);
    status.pos_is_one  = (pos == CNT_W'(1));
    status.greater     = (rd_data > value);
    status.more        = (pos_p1 < count);
    status.out_busy    = out_valid && !out_ready;
  end

  `SAPQ_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `SAPQ_ASSERT(a_no_overwrite, clk, rst, cmd.out_load |-> (!out_valid || out_ready))
  `SAPQ_ASSERT(a_count_on_finish, clk, rst, !cmd.out_load |=> $stable(count))
  `SAPQ_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (count == '0 && !out_valid))

endmodule

`default_nettype wire

[hw/rtl/sorted_array_min_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_array_min_priority_queue
// minimum priority queue of signed values kept in ascending order
// ----------------------------------------------------------------------------
// requests arrive on the in channel (req_type, insert_value); each request
// gives one result beat on the out channel (status, removed_value,
// entry_count). an insert into a full queue returns full, a remove from an
// empty queue returns empty with value 0.
// entries live in a single-port-write, single-port-read memory; an insert
// walks down from the tail, shifting larger entries up one slot a cycle, a
// remove reads the head and shifts the rest down one slot a cycle.
// the walk does one memory access a cycle, so an insert or remove takes longer
// the more entries the queue holds; an insert walk stops at the first entry
// not larger than its value, and a refused request skips the walk. the
// controller returns to idle after each result loads, before the next request
// is accepted, so requests are handled one at a time.
// a new request is accepted while the previous result still waits in the
// output register; if the receiver stalls, the finished request holds
// until the output register frees.
// reset empties the queue and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_min_priority_queue #(
  parameter int CAPACITY = sapq_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  req_type,
  input  logic signed [sapq_pkg::VALUE_W-1:0]   insert_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sapq_pkg::STATUS_W-1:0]         status,
  output logic signed [sapq_pkg::VALUE_W-1:0]   removed_value,
  output logic [sapq_pkg::COUNT_OUT_W-1:0]      entry_count
);

  import sapq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  sapq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (cmd)
  );

  sapq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (dp_status),
    .req_type     (req_type),
    .insert_value (insert_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (status),
    .out_removed  (removed_value),
    .out_count    (entry_count)
  );

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// testbench of the sorted array min priority queue: every request beat is
// run through a local queue model and the result beats are compared field by
// field, in order, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import sapq_pkg::*;

  localparam int QCAP         = CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_SHOWN    = 10;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_OUT_W-1:0]    count;
  } pq_result_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic                        req_type;
  logic signed [VALUE_W-1:0]   insert_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [STATUS_W-1:0]         status;
  logic signed [VALUE_W-1:0]   removed_value;
  logic [COUNT_OUT_W-1:0]      entry_count;

  // local copy of the queue contents, ascending
  logic signed [VALUE_W-1:0] model_entries[$];
  pq_result_t                pending_results[$];

  int     mismatches  = 0;
  int     cycle_count = 0;
  int     n_inserted  = 0;
  int     n_removed   = 0;
  int     n_full      = 0;
  int     n_empty     = 0;
  int     n_requests  = 0;
  int     rx_hold     = 0;
  bit     rx_steady   = 1'b0;
  bit     tx_burst    = 1'b0;

  sorted_array_min_priority_queue #(
    .CAPACITY(QCAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .insert_value (insert_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .removed_value(removed_value),
    .entry_count  (entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // queue behavior for one accepted request
  function automatic pq_result_t predict_queue_op(logic rtype,
                                                  logic signed [VALUE_W-1:0] v);
    pq_result_t r;
    int         pos;
    r.status = ST_DONE;
    r.value  = '0;
    if (rtype == REQ_INSERT) begin
      if (model_entries.size() >= QCAP) begin
        r.status = ST_FULL;
      end else begin
        // ties go behind the stored equal values
        pos = model_entries.size();
        while (pos > 0 && model_entries[pos-1] > v) pos--;
        model_entries.insert(pos, v);
      end
    end else begin
      if (model_entries.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value = model_entries.pop_front();
      end
    end
    r.count = (model_entries.size() > 15) ? 4'd15 : COUNT_OUT_W'(model_entries.size());
    return r;
  endfunction

  // result channel: ready pattern driven at the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pq_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("[%0d] result beat with nothing expected: st=%0d val=%0d cnt=%0d",
                   cycle_count, status, removed_value, entry_count);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || removed_value !== want.value ||
            entry_count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("[%0d] mismatch: expected st=%0d val=%0d cnt=%0d, got st=%0d val=%0d cnt=%0d",
                     cycle_count, want.status, want.value, want.count,
                     status, removed_value, entry_count);
        end
        case (want.status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          default:  ;
        endcase
      end
      rx_hold = rx_steady ? 0 : $urandom_range(0, 13);
    end
  end

  // one request beat; leaves valid high, lowered by go_idle or by a gap in the next call
  task automatic send_request(input logic rtype, input logic signed [VALUE_W-1:0] v);
    int unsigned gap;
    pq_result_t  r;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= rtype;
    insert_value <= v;
    do @(posedge clk); while (!in_ready);
    r = predict_queue_op(rtype, v);
    if (r.status == ST_DONE) begin
      if (rtype == REQ_INSERT) n_inserted++;
      else n_removed++;
    end
    n_requests++;
    pending_results.push_back(r);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results_done();
    go_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3, 4: return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_remove_empty();
    send_request(REQ_REMOVE, VAL_MAX);
    send_request(REQ_REMOVE, '0);
  endtask

  // extremes and ties until full, then one refused insert
  task automatic test_fill_extremes();
    send_request(REQ_INSERT, VAL_MAX);
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, -32'sd1);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_INSERT, VAL_MAX);
    send_request(REQ_INSERT, 32'sd1);
    repeat (QCAP - 8) send_request(REQ_INSERT, pick_value());
    send_request(REQ_INSERT, 32'sd7);
  endtask

  task automatic test_drain_sorted();
    repeat (QCAP + 1) send_request(REQ_REMOVE, pick_value());
  endtask

  // phases with different insert/remove mixes so the queue swings between
  // empty and full; a phase may end with the sender paused until all results are back
  task automatic test_random_traffic();
    int unsigned ins_pct;
    repeat (15) begin
      case ($urandom_range(0, 2))
        0:       ins_pct = 25;
        1:       ins_pct = 50;
        default: ins_pct = 75;
      endcase
      tx_burst  = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      repeat (50) begin
        if ($urandom_range(1, 100) <= ins_pct)
          send_request(REQ_INSERT, pick_value());
        else
          send_request(REQ_REMOVE, pick_value());
      end
      if ($urandom_range(0, 4) == 0) wait_results_done();
    end
    tx_burst  = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_INSERT;
    insert_value = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_remove_empty();
    test_fill_extremes();
    test_drain_sorted();
    wait_results_done();
    test_random_traffic();
    wait_results_done();

    $display("%0d requests: %0d inserts and %0d removes done, %0d refused full, %0d refused empty",
             n_requests, n_inserted, n_removed, n_full, n_empty);
    $display("random phases mixed insert-heavy and remove-heavy traffic with gaps and stalls");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/sapq_pkg.sv
hw/rtl/sapq_ctrl.sv
hw/rtl/sapq_dp.sv
hw/rtl/sorted_array_min_priority_queue.sv
dv/tb.sv
